// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_RST(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Clocked property that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== src/pfdw_pkg.sv =====
// Types, codes and helper functions of the page frame buffer block.
package pfdw_pkg;

  typedef enum logic [2:0] {
    ACT_PIXEL   = 3'd0,
    ACT_HLINE   = 3'd1,
    ACT_VLINE   = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_READ    = 3'd4,
    ACT_REFRESH = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    INK_SET    = 2'd0,
    INK_CLEAR  = 2'd1,
    INK_INVERT = 2'd2,
    INK_KEEP   = 2'd3
  } ink_t;

  typedef enum logic [1:0] {
    RK_NONE    = 2'd0,
    RK_FULL    = 2'd1,
    RK_PARTIAL = 2'd2
  } refresh_kind_t;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_DECODE = 3'd2,
    S_RUN    = 3'd3,
    S_DRAIN  = 3'd4,
    S_FINISH = 3'd5
  } state_t;

  // Register places on the configuration port
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [7:0] WIDTH_RST     = 8'd128;
  localparam logic [6:0] HEIGHT_RST    = 7'd64;
  localparam logic [7:0] WIN_LO_RST    = 8'hFF;
  localparam logic [7:0] WIN_HI_RST    = 8'h00;
  localparam logic [7:0] FULL_COL_END  = 8'd127;
  localparam logic [7:0] BYTE_ALL      = 8'hFF;

  function automatic logic [7:0] ink_apply(input logic [7:0] d, input logic [7:0] m,
                                           input ink_t k);
    logic [7:0] r;
    case (k)
      INK_SET:    r = d | m;
      INK_CLEAR:  r = d & ~m;
      INK_INVERT: r = d ^ m;
      default:    r = d;
    endcase
    return r;
  endfunction

  // Rows lo..hi of one page byte
  function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
    return (BYTE_ALL << lo) & (BYTE_ALL >> (3'd7 - hi));
  endfunction

endpackage

// ===== src/pfdw_store.sv =====
// Byte-wide pixel store: one write port, one registered read port.
module pfdw_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/page_framebuffer_draw_dirty_window_top.sv =====
// Monochrome page frame buffer with dirty rectangle: top level.
//
// Commands are taken when start is high and busy is low; every command gives
// exactly one result, shown for one cycle with out_strobe high, which the
// receiver must take then. Pixels sit in a single-port-read byte memory of
// MAX_COLUMNS*MAX_PAGES bytes, one byte per column and 8-row page, and every
// byte a draw command touches is read, modified and written back at one byte
// per cycle through that read port; a read command only reads its byte. Pixel,
// line and read commands pass through decode, a run over their bytes, drain
// and finish; refresh and ignored commands go from decode straight to finish.
// The result cycle itself accepts the next item. A clear sweeps every byte to
// zero. After reset the same sweep runs with busy high and gives no result;
// configuration writes are taken throughout. Write panel_width (byte 0) and
// panel_height (byte 4) only while no command is in flight.
module page_framebuffer_draw_dirty_window_top
  import pfdw_pkg::*;
#(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  // command channel
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_action,
  input  logic [7:0] in_col,
  input  logic [7:0] in_row,
  input  logic [7:0] in_run_length,
  input  logic [1:0] in_ink,
  input  logic       in_force_full,
  // result channel
  output logic       out_strobe,
  output logic [7:0] out_read_data,
  output logic [1:0] out_refresh_kind,
  output logic [7:0] out_column_start,
  output logic [7:0] out_column_end,
  output logic [2:0] out_first_page,
  output logic [2:0] out_last_page,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "assert_macros.svh"

  localparam int STORE_BYTES = MAX_COLUMNS * MAX_PAGES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
  localparam logic [7:0]    MAX_W     = 8'(MAX_COLUMNS);
  localparam logic [6:0]    MAX_H     = 7'(8 * MAX_PAGES);

  // ---------------------------------------------------------------- config
  logic [7:0] panel_width_r;
  logic [6:0] panel_height_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r  <= WIDTH_RST;
      panel_height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        panel_width_r <= pwdata[7:0];
      end else begin
        panel_height_r <= pwdata[6:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? {25'd0, panel_height_r} : {24'd0, panel_width_r};

  // Effective panel size, clamped to the store
  logic [7:0] w;
  logic [6:0] h;
  assign w = (panel_width_r < MAX_W) ? panel_width_r : MAX_W;
  assign h = (panel_height_r < MAX_H) ? panel_height_r : MAX_H;

  // ---------------------------------------------------------------- state
  state_t state_r, state_nxt;

  // command as taken
  action_t    act_r;
  logic [7:0] col_r, row_r, len_r;
  ink_t       ink_r;
  logic       force_r;

  // decoded command
  logic          ok_r;        // pixel, line or read command that lands on the panel
  logic          is_vline_r;
  logic [2:0]    first_pg_r, last_pg_r;
  logic [5:0]    last_row_r;
  logic [7:0]    edge_r_r, edge_b_r;
  logic [7:0]    cnt_r;
  logic [2:0]    page_r;
  logic [AW-1:0] addr_r;      // run address, or sweep address while clearing
  logic          clr_cmd_r;   // sweep belongs to a clear command

  // write-back stage
  logic          wr_pend_r;
  logic [AW-1:0] wr_addr_r;
  logic [7:0]    mask_r;
  logic [7:0]    rdata_r;

  // dirty window
  logic [7:0] dirty_top_r, dirty_left_r, dirty_right_r, dirty_bottom_r;

  // result registers
  logic          out_strobe_r;
  logic [7:0]    out_read_data_r, out_read_data_nxt;
  refresh_kind_t out_kind_r, out_kind_nxt;
  logic [7:0]    out_cs_r, out_cs_nxt, out_ce_r, out_ce_nxt;
  logic [2:0]    out_fp_r, out_fp_nxt, out_lp_r, out_lp_nxt;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  pfdw_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------- decode
  logic          d_inside, d_ok, d_hclip, d_vclip;
  logic [8:0]    d_hsum, d_vsum;
  logic [7:0]    d_hlen, d_hright, d_vlast;
  logic [2:0]    d_first_pg, d_last_pg;
  logic [11:0]   d_base;
  logic [7:0]    d_cnt;

  always_comb begin
    d_inside   = (col_r < w) && (row_r < {1'b0, h});
    d_ok       = d_inside && ((act_r == ACT_PIXEL) || (act_r == ACT_READ) ||
                 (((act_r == ACT_HLINE) || (act_r == ACT_VLINE)) && (len_r != 8'd0)));
    d_hsum     = {1'b0, col_r} + {1'b0, len_r};
    d_hclip    = d_hsum > {1'b0, w};
    d_hlen     = d_hclip ? (w - col_r) : len_r;
    d_hright   = d_hclip ? (w - 8'd1) : (d_hsum[7:0] - 8'd1);
    d_vsum     = {1'b0, row_r} + {1'b0, len_r};
    d_vclip    = d_vsum > {2'b0, h};
    d_vlast    = d_vclip ? ({1'b0, h} - 8'd1) : (d_vsum[7:0] - 8'd1);
    d_first_pg = row_r[5:3];
    d_last_pg  = d_vlast[5:3];
    // page start address: col + page * width
    d_base     = {4'd0, col_r} + ({9'd0, d_first_pg} * {4'd0, w});
    case (act_r)
      ACT_HLINE: d_cnt = d_hlen;
      ACT_VLINE: d_cnt = {4'd0, {1'b0, d_last_pg} - {1'b0, d_first_pg} + 4'd1};
      default:   d_cnt = 8'd1;
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = clr_cmd_r ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (act_r == ACT_CLEAR) begin
          state_nxt = S_CLEAR;
        end else if (d_ok) begin
          state_nxt = S_RUN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_RUN: begin
        if (cnt_r == 8'd1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  logic [7:0] run_mask;
  logic [2:0] run_lo, run_hi;
  logic       win_whole, win_nonempty;
  logic [2:0] full_last_pg;

  always_comb begin
    busy = (state_r != S_IDLE);

    // byte mask for the byte read this cycle
    run_lo   = (page_r == first_pg_r) ? row_r[2:0] : 3'd0;
    run_hi   = (page_r == last_pg_r) ? last_row_r[2:0] : 3'd7;
    run_mask = is_vline_r ? span_mask(run_lo, run_hi) : (8'h01 << row_r[2:0]);

    // memory write: clearing sweep or read-modify-write back
    mem_we    = 1'b0;
    mem_waddr = wr_addr_r;
    mem_wdata = ink_apply(mem_rdata, mask_r, ink_r);
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = addr_r;
      mem_wdata = 8'd0;
    end else if (wr_pend_r) begin
      mem_we = 1'b1;
    end

    // refresh report
    win_whole    = (dirty_top_r == 8'd0) && (dirty_left_r == 8'd0) &&
                   (({1'b0, dirty_bottom_r} + 9'd1) >= {2'b0, h}) &&
                   (({1'b0, dirty_right_r} + 9'd1) >= {1'b0, w});
    win_nonempty = (dirty_top_r <= dirty_bottom_r) && (dirty_left_r <= dirty_right_r);
    full_last_pg = (h[6:3] == 4'd0) ? 3'd0 : 3'(h[6:3] - 4'd1);

    out_read_data_nxt = 8'd0;
    out_kind_nxt      = RK_NONE;
    out_cs_nxt        = 8'd0;
    out_ce_nxt        = 8'd0;
    out_fp_nxt        = 3'd0;
    out_lp_nxt        = 3'd0;
    case (act_r)
      ACT_READ: begin
        if (ok_r) begin
          out_read_data_nxt = rdata_r;
        end
      end
      ACT_REFRESH: begin
        if (force_r || win_whole) begin
          out_kind_nxt = RK_FULL;
          out_ce_nxt   = FULL_COL_END;
          out_lp_nxt   = full_last_pg;
        end else if (win_nonempty) begin
          out_kind_nxt = RK_PARTIAL;
          out_cs_nxt   = dirty_left_r;
          out_ce_nxt   = dirty_right_r;
          out_fp_nxt   = dirty_top_r[5:3];
          out_lp_nxt   = dirty_bottom_r[5:3];
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;      // zeroing sweep after reset
      addr_r    <= '0;
      clr_cmd_r <= 1'b0;
      wr_pend_r <= 1'b0;
      out_strobe_r   <= 1'b0;
      dirty_top_r    <= WIN_LO_RST;
      dirty_left_r   <= WIN_LO_RST;
      dirty_right_r  <= WIN_HI_RST;
      dirty_bottom_r <= WIN_HI_RST;
    end else begin
      state_r      <= state_nxt;
      wr_pend_r    <= (state_r == S_RUN) && (act_r != ACT_READ);
      out_strobe_r <= (state_r == S_FINISH);

      case (state_r)
        S_CLEAR: addr_r <= addr_r + 1'b1;
        S_DECODE: begin
          clr_cmd_r <= (act_r == ACT_CLEAR);
          addr_r    <= (act_r == ACT_CLEAR) ? '0 : d_base[AW-1:0];
        end
        S_RUN: addr_r <= addr_r + (is_vline_r ? AW'(w) : AW'(1));
        S_FINISH: begin
          case (act_r)
            ACT_PIXEL, ACT_HLINE, ACT_VLINE: begin
              if (ok_r) begin
                if (col_r < dirty_left_r)      dirty_left_r   <= col_r;
                if (edge_r_r > dirty_right_r)  dirty_right_r  <= edge_r_r;
                if (row_r < dirty_top_r)       dirty_top_r    <= row_r;
                if (edge_b_r > dirty_bottom_r) dirty_bottom_r <= edge_b_r;
              end
            end
            ACT_CLEAR: begin
              dirty_left_r   <= 8'd0;
              dirty_top_r    <= 8'd0;
              dirty_right_r  <= w - 8'd1;
              dirty_bottom_r <= {1'b0, h} - 8'd1;
            end
            ACT_REFRESH: begin
              dirty_top_r    <= WIN_LO_RST;
              dirty_left_r   <= WIN_LO_RST;
              dirty_right_r  <= WIN_HI_RST;
              dirty_bottom_r <= WIN_HI_RST;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      act_r   <= action_t'(in_action);
      col_r   <= in_col;
      row_r   <= in_row;
      len_r   <= in_run_length;
      ink_r   <= ink_t'(in_ink);
      force_r <= in_force_full;
    end
    if (state_r == S_DECODE) begin
      ok_r       <= d_ok;
      is_vline_r <= (act_r == ACT_VLINE);
      first_pg_r <= d_first_pg;
      last_pg_r  <= d_last_pg;
      last_row_r <= d_vlast[5:0];
      edge_r_r   <= (act_r == ACT_HLINE) ? d_hright : col_r;
      edge_b_r   <= (act_r == ACT_VLINE) ? d_vlast : row_r;
      cnt_r      <= d_cnt;
      page_r     <= d_first_pg;
      rdata_r    <= 8'd0;
    end
    if (state_r == S_RUN) begin
      wr_addr_r <= addr_r;
      mask_r    <= run_mask;
      cnt_r     <= cnt_r - 8'd1;
      page_r    <= page_r + 3'd1;
    end
    if (state_r == S_DRAIN) begin
      rdata_r <= mem_rdata;
    end
    if (state_r == S_FINISH) begin
      out_read_data_r <= out_read_data_nxt;
      out_kind_r      <= out_kind_nxt;
      out_cs_r        <= out_cs_nxt;
      out_ce_r        <= out_ce_nxt;
      out_fp_r        <= out_fp_nxt;
      out_lp_r        <= out_lp_nxt;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_read_data    = out_read_data_r;
  assign out_refresh_kind = out_kind_r;
  assign out_column_start = out_cs_r;
  assign out_column_end   = out_ce_r;
  assign out_first_page   = out_fp_r;
  assign out_last_page    = out_lp_r;

  // ---------------------------------------------------------------- checks
  `ASSERT_ALWAYS(a_reset_sweep, clk, (!rst_n) |=> (state_r == S_CLEAR) && (addr_r == '0), "reset must restart the zeroing sweep")
  `ASSERT_RST(a_strobe_src, clk, rst_n, out_strobe_r |-> $past(state_r == S_FINISH), "result strobe without a finished command")
  `ASSERT_RST(a_wr_range, clk, rst_n, wr_pend_r |-> (wr_addr_r <= LAST_ADDR), "write-back beyond the store")
  `ASSERT_RST(a_we_state, clk, rst_n, mem_we |-> (state_r == S_RUN || state_r == S_DRAIN || state_r == S_CLEAR), "store written outside a command")
  `ASSERT_RST(a_refresh_empties, clk, rst_n, (state_r == S_FINISH && act_r == ACT_REFRESH) |=> (dirty_left_r == WIN_LO_RST && dirty_bottom_r == WIN_HI_RST), "refresh left the window open")

endmodule
